/* rtl/stha_pkg.sv */
// Shared types, mode codes and helpers of the staged temperature hold controller.
package stha_pkg;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_HEAT = 2'd1;
	localparam logic [1:0] MODE_HOLD = 2'd2;
	localparam logic [1:0] MODE_COOL = 2'd3;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 72;

	typedef struct packed {
		logic [1:0] level;
		logic       pump;
		logic [1:0] mode;
	} band_t;

	typedef struct packed {
		logic [7:0]  aim;
		logic [3:0]  active_step;
		logic [15:0] hold_seconds;
		logic [15:0] heat_seconds;
		logic [15:0] cool_seconds;
		logic        step_done;
		logic        program_done;
	} step_view_t;

	// saturating add of an elapsed time to a 16-bit counter
	function automatic logic [15:0] sat_add(input logic [15:0] c, input logic [31:0] d);
		logic [32:0] sum;
		sum = 33'(c) + 33'(d);
		return (sum >= 33'd65535) ? 16'hFFFF : sum[15:0];
	endfunction

endpackage

/* rtl/stha_band.sv */
// Temperature band classifier: heater level, pump and timing mode around the aim.
module stha_band #(
	parameter int TEMP_FRACTION_BITS = 4
) (
	input  logic [7:0]         aim,
	input  logic signed [11:0] temperature,
	output stha_pkg::band_t    band
);

	localparam int WW = 8 + TEMP_FRACTION_BITS + 5;

	logic signed [WW-1:0] t, a, sc, lo3, lo2, lo1, hi1;

	always_comb begin
		t   = WW'(temperature);
		a   = $signed(WW'(aim) << TEMP_FRACTION_BITS);
		sc  = $signed(WW'(1) << TEMP_FRACTION_BITS);
		lo3 = a - sc - sc - sc;
		lo2 = a - sc - sc;
		lo1 = a - sc;
		hi1 = a + sc;
		if (t < lo3) begin
			band = '{level: 2'd3, pump: 1'b1, mode: stha_pkg::MODE_HEAT};
		end else if (t < lo2) begin
			band = '{level: 2'd2, pump: 1'b1, mode: stha_pkg::MODE_HEAT};
		end else if (t < lo1) begin
			band = '{level: 2'd1, pump: 1'b1, mode: stha_pkg::MODE_HEAT};
		end else if (t < a) begin
			band = '{level: 2'd1, pump: 1'b1, mode: stha_pkg::MODE_HOLD};
		end else if (t <= hi1) begin
			band = '{level: 2'd0, pump: 1'b0, mode: stha_pkg::MODE_HOLD};
		end else begin
			band = '{level: 2'd0, pump: 1'b1, mode: stha_pkg::MODE_COOL};
		end
	end

endmodule

/* rtl/stha_steps.sv */
// Step table, per-step counters, step selection and time charging.
module stha_steps #(
	parameter int STEP_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 do_tick,
	input  logic                 do_write,
	input  logic [31:0]          now_seconds,
	input  logic [3:0]           step_index,
	input  logic [7:0]           step_target,
	input  logic [15:0]          step_duration,
	input  logic                 step_enabled,
	input  logic [1:0]           new_mode,
	output stha_pkg::step_view_t view
);

	localparam int IDX_W = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

	logic [7:0]  target_q   [STEP_COUNT];
	logic [15:0] duration_q [STEP_COUNT];
	logic [15:0] hold_q     [STEP_COUNT];
	logic [15:0] heat_q     [STEP_COUNT];
	logic [15:0] cool_q     [STEP_COUNT];
	logic [STEP_COUNT-1:0] enabled_q, completed_q;
	logic [IDX_W-1:0] served_q;
	logic [1:0]       mode_q;
	logic [31:0]      start_q;

	logic [STEP_COUNT-1:0] pending;
	logic [IDX_W-1:0]      first, sel, widx;
	logic                  found, wr_ok;
	logic [31:0]           elapsed;
	logic [15:0]           hold_n, heat_n, cool_n;
	logic                  done_n;

	always_comb begin
		pending = enabled_q & ~completed_q;
		found   = |pending;
		first   = '0;
		// lowest pending step wins
		for (int i = STEP_COUNT - 1; i >= 0; i--) begin
			if (pending[i]) begin
				first = IDX_W'(i);
			end
		end
		sel     = found ? first : served_q;
		elapsed = now_seconds - start_q;
		hold_n  = hold_q[sel];
		heat_n  = heat_q[sel];
		cool_n  = cool_q[sel];
		done_n  = completed_q[sel];
		case (mode_q)
			stha_pkg::MODE_HEAT: heat_n = stha_pkg::sat_add(heat_q[sel], elapsed);
			stha_pkg::MODE_COOL: cool_n = stha_pkg::sat_add(cool_q[sel], elapsed);
			stha_pkg::MODE_HOLD: begin
				hold_n = stha_pkg::sat_add(hold_q[sel], elapsed);
				done_n = hold_n > duration_q[sel];
			end
			default: ;
		endcase
		view.aim          = found ? target_q[first] : 8'd0;
		view.active_step  = 4'(sel);
		view.hold_seconds = hold_n;
		view.heat_seconds = heat_n;
		view.cool_seconds = cool_n;
		view.step_done    = done_n;
		view.program_done = !found;
		wr_ok = 32'(step_index) < STEP_COUNT;
		widx  = IDX_W'(step_index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STEP_COUNT; i++) begin
				target_q[i]   <= '0;
				duration_q[i] <= '0;
				hold_q[i]     <= '0;
				heat_q[i]     <= '0;
				cool_q[i]     <= '0;
			end
			enabled_q   <= '0;
			completed_q <= '0;
			served_q    <= '0;
			mode_q      <= stha_pkg::MODE_NONE;
			start_q     <= '0;
		end else if (do_write) begin
			if (wr_ok) begin
				target_q[widx]    <= step_target;
				duration_q[widx]  <= step_duration;
				enabled_q[widx]   <= step_enabled;
				completed_q[widx] <= 1'b0;
				hold_q[widx]      <= '0;
				heat_q[widx]      <= '0;
				cool_q[widx]      <= '0;
			end
		end else if (do_tick) begin
			served_q         <= sel;
			hold_q[sel]      <= hold_n;
			heat_q[sel]      <= heat_n;
			cool_q[sel]      <= cool_n;
			completed_q[sel] <= done_n;
			mode_q           <= new_mode;
			start_q          <= now_seconds;
		end
	end

endmodule

/* rtl/staged_temperature_hold_controller_core.sv */
// Top level of the staged temperature hold controller: stream ports and beat registers.
// A tick passes the input beat and result registers to m_tvalid; a write gives no result.
// Throughput: one beat per cycle while no tick stalls, ticks and table writes alike.
// The cycle is set by one priority encode over the steps, a 33-bit charge add and compare.
// A tick held behind an unread result stalls the input, so s_tready then follows m_tready.
// Reset (arst_n low, asynchronous) clears the step table, counters, flags and mode at once.
module staged_temperature_hold_controller_core #(
	parameter int STEP_COUNT         = 16,
	parameter int TEMP_FRACTION_BITS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// now_seconds[31:0], temperature[43:32], step_index[47:44], step_target[55:48],
	// step_duration[71:56], step_enabled[72], zero fill [79:73]
	input  logic [stha_pkg::IN_DATA_W-1:0]  s_tdata,
	// kind[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// heater_level[1:0], pump_on[2], timing_mode[4:3], aim_temp[12:5], active_step[16:13],
	// hold_seconds[32:17], heat_seconds[48:33], cool_seconds[64:49], step_done[65],
	// program_done[66], zero fill [71:67]
	output logic [stha_pkg::OUT_DATA_W-1:0] m_tdata
);

	// input beat register
	logic                           valid_s1;
	logic                           kind_s1;
	logic [stha_pkg::IN_DATA_W-1:0] data_s1;

	// result register
	logic                            valid_s2;
	logic [stha_pkg::OUT_DATA_W-1:0] data_s2;

	logic advance, adv_tick, adv_write;
	stha_pkg::band_t      band;
	stha_pkg::step_view_t view;

	// advance the held beat: writes always go, ticks need room in the result register
	assign advance   = valid_s1 && (kind_s1 == stha_pkg::KIND_WRITE || !valid_s2 || m_tready);
	assign adv_tick  = advance && kind_s1 == stha_pkg::KIND_TICK;
	assign adv_write = advance && kind_s1 == stha_pkg::KIND_WRITE;
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			data_s1 <= s_tdata;
		end
	end

	stha_steps #(
		.STEP_COUNT(STEP_COUNT)
	) u_steps (
		.clk          (clk),
		.arst_n       (arst_n),
		.do_tick      (adv_tick),
		.do_write     (adv_write),
		.now_seconds  (data_s1[31:0]),
		.step_index   (data_s1[47:44]),
		.step_target  (data_s1[55:48]),
		.step_duration(data_s1[71:56]),
		.step_enabled (data_s1[72]),
		.new_mode     (band.mode),
		.view         (view)
	);

	// bands are placed around the aim chosen before this tick's charge
	stha_band #(
		.TEMP_FRACTION_BITS(TEMP_FRACTION_BITS)
	) u_band (
		.aim        (view.aim),
		.temperature($signed(data_s1[43:32])),
		.band       (band)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_tick) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk) begin
		if (adv_tick) begin
			data_s2 <= {5'd0, view.program_done, view.step_done, view.cool_seconds,
				view.heat_seconds, view.hold_seconds, view.active_step, view.aim,
				band.mode, band.pump, band.level};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

`ifndef SYNTHESIS
	// a result beat only appears after a tick left the input register
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(adv_tick))
		else $error("result beat without a tick");

	// a finished program always aims at zero
	a_done_aim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[66] |-> m_tdata[12:5] == 8'd0)
		else $error("program done with nonzero aim");

	// a tick blocked by a stalled result blocks the input side
	a_tick_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && kind_s1 == stha_pkg::KIND_TICK && m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while tick is stalled");
`endif

endmodule
